FILE: src/mouse_frame_report_engine_macros.svh
// assertion macros for the mouse frame report engine checker
`ifndef MOUSE_FRAME_REPORT_ENGINE_MACROS_SVH
`define MOUSE_FRAME_REPORT_ENGINE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define MFRE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define MFRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mfre_pkg.sv
// shared constants for the mouse frame report engine
package mfre_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int HIST_W      = 8;
    localparam int MOTION_W    = 16;
    localparam int SKIP_W      = 8;
    localparam int PROFILE_W   = 2;
    localparam int CPI_CODE_W  = 4;
    localparam int WHEEL_W     = 2;
    localparam int CFG_DATA_W  = 8;

    // register indexes of the configuration port
    localparam logic CFG_INITIAL_PROFILE = 1'b0;
    localparam logic CFG_INITIAL_SKIP    = 1'b1;

    // debounce patterns
    localparam logic [HIST_W-1:0] PRESS_PAT     = 8'hFE;
    localparam logic [HIST_W-1:0] RELEASE_PAT_A = 8'h01;
    localparam logic [HIST_W-1:0] RELEASE_PAT_B = 8'hFF;

    // pin to report bit map
    localparam logic [NUM_BUTTONS-1:0] KEY_BIT [NUM_BUTTONS] = '{
        5'h04, 5'h08, 5'h10, 5'h02, 5'h01
    };

    // button combos on pressed flags
    localparam logic [NUM_BUTTONS-1:0] CPI_COMBO  = 5'h13;
    localparam logic [NUM_BUTTONS-1:0] RATE_COMBO = 5'h1B;

    // cpi profiles and sensor codes
    localparam logic [PROFILE_W-1:0]  PROFILE_0 = 2'd0;
    localparam logic [PROFILE_W-1:0]  PROFILE_1 = 2'd1;
    localparam logic [PROFILE_W-1:0]  PROFILE_2 = 2'd2;
    localparam logic [CPI_CODE_W-1:0] CPI_CODE_NONE = 4'h0;
    localparam logic [CPI_CODE_W-1:0] CPI_CODE_P0   = 4'h3;
    localparam logic [CPI_CODE_W-1:0] CPI_CODE_P1   = 4'h7;
    localparam logic [CPI_CODE_W-1:0] CPI_CODE_P2   = 4'hF;

    // report skip cycle
    localparam logic [SKIP_W-1:0] SKIP_0   = 8'd0;
    localparam logic [SKIP_W-1:0] SKIP_1   = 8'd1;
    localparam logic [SKIP_W-1:0] SKIP_3   = 8'd3;
    localparam logic [SKIP_W-1:0] SKIP_7   = 8'd7;
    localparam logic [SKIP_W-1:0] SKIP_MAX = 8'hFE;
    localparam logic [SKIP_W-1:0] SKIP_SAT = 8'hFF;

    // wheel steps
    localparam logic signed [WHEEL_W-1:0] WHEEL_NONE = 2'sb00;
    localparam logic signed [WHEEL_W-1:0] WHEEL_POS  = 2'sb01;
    localparam logic signed [WHEEL_W-1:0] WHEEL_NEG  = 2'sb11;

endpackage

FILE: src/mouse_frame_report_engine.sv
// mouse frame report engine: debounce, wheel decode, motion accumulate, report
//
// one transfer on the input channel per usb frame: button pins, wheel pins
// and sensor deltas, taken when in_valid is high and in_stall is low
// every input transfer gives exactly one output transfer carrying the report
// decision, the profile state and the skip state for that frame
// each frame passes an input register, then the frame logic into the result
// register; one frame per cycle is sustained while out_stall is low
// when the receiver stalls the result register holds and one more frame can
// wait in the input register; after that in_stall goes high
// configuration writes load the cpi profile and the skip setting directly;
// a skip value of 255 is held as 254; write only while no frame is in flight
// reset clears both registers' valid flags and all frame state
module mouse_frame_report_engine
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic                                   cfg_index,
    input  logic [mfre_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [mfre_pkg::NUM_BUTTONS-1:0]       button_pins,
    input  logic                                   wheel_a,
    input  logic                                   wheel_b,
    input  logic signed [mfre_pkg::MOTION_W-1:0]   delta_x,
    input  logic signed [mfre_pkg::MOTION_W-1:0]   delta_y,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   report_valid,
    output logic [mfre_pkg::NUM_BUTTONS-1:0]       report_buttons,
    output logic signed [mfre_pkg::MOTION_W-1:0]   report_x,
    output logic signed [mfre_pkg::MOTION_W-1:0]   report_y,
    output logic signed [mfre_pkg::WHEEL_W-1:0]    report_wheel,
    output logic                                   profile_changed,
    output logic [mfre_pkg::PROFILE_W-1:0]         new_profile,
    output logic [mfre_pkg::CPI_CODE_W-1:0]        sensor_cpi_code,
    output logic                                   rate_changed,
    output logic [mfre_pkg::SKIP_W-1:0]            new_skip
);

    // input register
    logic                                   in_full_reg;
    logic                                   in_full_next;
    logic [mfre_pkg::NUM_BUTTONS-1:0]       pins_reg;
    logic                                   wa_reg;
    logic                                   wb_reg;
    logic [mfre_pkg::MOTION_W-1:0]          dx_reg;
    logic [mfre_pkg::MOTION_W-1:0]          dy_reg;

    // frame state
    logic [mfre_pkg::HIST_W-1:0]            hist_reg [mfre_pkg::NUM_BUTTONS];
    logic [mfre_pkg::HIST_W-1:0]            hist_next [mfre_pkg::NUM_BUTTONS];
    logic [mfre_pkg::NUM_BUTTONS-1:0]       pressed_reg;
    logic [mfre_pkg::NUM_BUTTONS-1:0]       pressed_next;
    logic [mfre_pkg::NUM_BUTTONS-1:0]       buttons_reg;
    logic [mfre_pkg::NUM_BUTTONS-1:0]       buttons_next;
    logic [mfre_pkg::NUM_BUTTONS-1:0]       sent_reg;
    logic [mfre_pkg::NUM_BUTTONS-1:0]       sent_next;
    logic                                   last_same_reg;
    logic                                   last_same_next;
    logic                                   last_diff_reg;
    logic                                   last_diff_next;
    logic [mfre_pkg::MOTION_W-1:0]          accum_x_reg;
    logic [mfre_pkg::MOTION_W-1:0]          accum_x_next;
    logic [mfre_pkg::MOTION_W-1:0]          accum_y_reg;
    logic [mfre_pkg::MOTION_W-1:0]          accum_y_next;
    logic [mfre_pkg::SKIP_W-1:0]            skip_cnt_reg;
    logic [mfre_pkg::SKIP_W-1:0]            skip_cnt_next;
    logic [mfre_pkg::SKIP_W-1:0]            skip_set_reg;
    logic [mfre_pkg::SKIP_W-1:0]            skip_set_next;
    logic [mfre_pkg::PROFILE_W-1:0]         profile_reg;
    logic [mfre_pkg::PROFILE_W-1:0]         profile_next;
    logic                                   cpi_armed_reg;
    logic                                   cpi_armed_next;
    logic                                   rate_armed_reg;
    logic                                   rate_armed_next;

    // result register
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic                                   rep_valid_reg;
    logic [mfre_pkg::NUM_BUTTONS-1:0]       rep_buttons_reg;
    logic signed [mfre_pkg::MOTION_W-1:0]   rep_x_reg;
    logic signed [mfre_pkg::MOTION_W-1:0]   rep_y_reg;
    logic signed [mfre_pkg::WHEEL_W-1:0]    rep_wheel_reg;
    logic                                   prof_chg_reg;
    logic [mfre_pkg::CPI_CODE_W-1:0]        cpi_code_reg;
    logic                                   rate_chg_reg;

    // frame logic results
    logic                                   in_accept;
    logic                                   advance;
    logic                                   cpi_all;
    logic                                   rate_all;
    logic                                   prof_chg_step;
    logic [mfre_pkg::CPI_CODE_W-1:0]        cpi_code_step;
    logic                                   rate_chg_step;
    logic signed [mfre_pkg::WHEEL_W-1:0]    wheel_step;
    logic                                   send;
    logic [mfre_pkg::HIST_W-1:0]            hist_step [mfre_pkg::NUM_BUTTONS];
    logic [mfre_pkg::NUM_BUTTONS-1:0]       pressed_step;
    logic [mfre_pkg::NUM_BUTTONS-1:0]       buttons_step;
    logic [mfre_pkg::PROFILE_W-1:0]         profile_step;
    logic                                   cpi_armed_step;
    logic [mfre_pkg::SKIP_W-1:0]            skip_set_step;
    logic                                   rate_armed_step;
    logic                                   last_same_step;
    logic                                   last_diff_step;
    logic [mfre_pkg::MOTION_W-1:0]          sum_x;
    logic [mfre_pkg::MOTION_W-1:0]          sum_y;

    assign advance   = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign in_full_next   = in_accept || (in_full_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    // debounce and button map
    always_comb
    begin
        pressed_step = pressed_reg;
        buttons_step = buttons_reg;
        for (int i = 0; i < mfre_pkg::NUM_BUTTONS; i++)
        begin
            hist_step[i] = {hist_reg[i][mfre_pkg::HIST_W-2:0], pins_reg[i]};
            if (!pressed_reg[i] && hist_step[i] == mfre_pkg::PRESS_PAT)
            begin
                pressed_step[i] = 1'b1;
                buttons_step    = buttons_step | mfre_pkg::KEY_BIT[i];
            end
            else if (pressed_reg[i] && (hist_step[i] == mfre_pkg::RELEASE_PAT_A ||
                                        hist_step[i] == mfre_pkg::RELEASE_PAT_B))
            begin
                pressed_step[i] = 1'b0;
                buttons_step    = buttons_step & ~mfre_pkg::KEY_BIT[i];
            end
        end
    end

    assign cpi_all  = (pressed_step & mfre_pkg::CPI_COMBO) == mfre_pkg::CPI_COMBO;
    assign rate_all = (pressed_step & mfre_pkg::RATE_COMBO) == mfre_pkg::RATE_COMBO;

    // cpi profile cycling on combo release
    always_comb
    begin
        profile_step   = profile_reg;
        cpi_armed_step = cpi_armed_reg;
        prof_chg_step  = 1'b0;
        cpi_code_step  = mfre_pkg::CPI_CODE_NONE;
        if (!cpi_all && cpi_armed_reg)
        begin
            cpi_armed_step = 1'b0;
            case (profile_reg)
                mfre_pkg::PROFILE_0:
                begin
                    profile_step  = mfre_pkg::PROFILE_1;
                    cpi_code_step = mfre_pkg::CPI_CODE_P1;
                    prof_chg_step = 1'b1;
                end
                mfre_pkg::PROFILE_1:
                begin
                    profile_step  = mfre_pkg::PROFILE_2;
                    cpi_code_step = mfre_pkg::CPI_CODE_P2;
                    prof_chg_step = 1'b1;
                end
                mfre_pkg::PROFILE_2:
                begin
                    profile_step  = mfre_pkg::PROFILE_0;
                    cpi_code_step = mfre_pkg::CPI_CODE_P0;
                    prof_chg_step = 1'b1;
                end
                default:
                begin
                    profile_step = profile_reg;
                end
            endcase
        end
        else if (cpi_all)
        begin
            cpi_armed_step = 1'b1;
        end
    end

    // report skip cycling on combo release
    always_comb
    begin
        skip_set_step   = skip_set_reg;
        rate_armed_step = rate_armed_reg;
        rate_chg_step   = 1'b0;
        if (!rate_all && rate_armed_reg)
        begin
            rate_armed_step = 1'b0;
            rate_chg_step   = 1'b1;
            case (skip_set_reg)
                mfre_pkg::SKIP_0: skip_set_step = mfre_pkg::SKIP_1;
                mfre_pkg::SKIP_1: skip_set_step = mfre_pkg::SKIP_3;
                mfre_pkg::SKIP_3: skip_set_step = mfre_pkg::SKIP_7;
                mfre_pkg::SKIP_7: skip_set_step = mfre_pkg::SKIP_0;
                default:          rate_chg_step = 1'b0;
            endcase
        end
        else if (rate_all)
        begin
            rate_armed_step = 1'b1;
        end
    end

    // quadrature wheel
    always_comb
    begin
        last_same_step = last_same_reg;
        last_diff_step = last_diff_reg;
        wheel_step     = mfre_pkg::WHEEL_NONE;
        if (wa_reg != wb_reg)
        begin
            last_diff_step = wa_reg;
        end
        else if (wa_reg != last_same_reg)
        begin
            wheel_step     = (wa_reg ^ last_diff_reg) ? mfre_pkg::WHEEL_NEG
                                                      : mfre_pkg::WHEEL_POS;
            last_same_step = wa_reg;
        end
    end

    assign sum_x = accum_x_reg + dx_reg;
    assign sum_y = accum_y_reg + dy_reg;

    assign send = (skip_cnt_reg == '0) &&
                  (sent_reg != buttons_step || sum_x != '0 || sum_y != '0 ||
                   wheel_step != mfre_pkg::WHEEL_NONE);

    // state next values; config writes must land only while idle, which the block does not enforce
    always_comb
    begin
        hist_next       = hist_reg;
        pressed_next    = pressed_reg;
        buttons_next    = buttons_reg;
        sent_next       = sent_reg;
        last_same_next  = last_same_reg;
        last_diff_next  = last_diff_reg;
        accum_x_next    = accum_x_reg;
        accum_y_next    = accum_y_reg;
        skip_cnt_next   = skip_cnt_reg;
        skip_set_next   = skip_set_reg;
        profile_next    = profile_reg;
        cpi_armed_next  = cpi_armed_reg;
        rate_armed_next = rate_armed_reg;
        if (advance)
        begin
            hist_next       = hist_step;
            pressed_next    = pressed_step;
            buttons_next    = buttons_step;
            last_same_next  = last_same_step;
            last_diff_next  = last_diff_step;
            skip_set_next   = skip_set_step;
            profile_next    = profile_step;
            cpi_armed_next  = cpi_armed_step;
            rate_armed_next = rate_armed_step;
            if (skip_cnt_reg != '0)
            begin
                skip_cnt_next = skip_cnt_reg - 1'b1;
                accum_x_next  = sum_x;
                accum_y_next  = sum_y;
            end
            else if (send)
            begin
                sent_next     = buttons_step;
                accum_x_next  = '0;
                accum_y_next  = '0;
                skip_cnt_next = skip_set_step;
            end
            else
            begin
                accum_x_next = sum_x;
                accum_y_next = sum_y;
            end
        end
        if (cfg_we)
        begin
            case (cfg_index)
                mfre_pkg::CFG_INITIAL_PROFILE:
                begin
                    profile_next = cfg_data[mfre_pkg::PROFILE_W-1:0];
                end
                mfre_pkg::CFG_INITIAL_SKIP:
                begin
                    skip_set_next = (cfg_data == mfre_pkg::SKIP_SAT) ? mfre_pkg::SKIP_MAX
                                                                     : cfg_data;
                end
                default:
                begin
                    profile_next = profile_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < mfre_pkg::NUM_BUTTONS; i++)
            begin
                hist_reg[i] <= '0;
            end
            pressed_reg    <= '0;
            buttons_reg    <= '0;
            sent_reg       <= '0;
            last_same_reg  <= 1'b0;
            last_diff_reg  <= 1'b0;
            accum_x_reg    <= '0;
            accum_y_reg    <= '0;
            skip_cnt_reg   <= '0;
            skip_set_reg   <= '0;
            profile_reg    <= '0;
            cpi_armed_reg  <= 1'b0;
            rate_armed_reg <= 1'b0;
        end
        else
        begin
            in_full_reg    <= in_full_next;
            out_valid_reg  <= out_valid_next;
            hist_reg       <= hist_next;
            pressed_reg    <= pressed_next;
            buttons_reg    <= buttons_next;
            sent_reg       <= sent_next;
            last_same_reg  <= last_same_next;
            last_diff_reg  <= last_diff_next;
            accum_x_reg    <= accum_x_next;
            accum_y_reg    <= accum_y_next;
            skip_cnt_reg   <= skip_cnt_next;
            skip_set_reg   <= skip_set_next;
            profile_reg    <= profile_next;
            cpi_armed_reg  <= cpi_armed_next;
            rate_armed_reg <= rate_armed_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pins_reg <= button_pins;
            wa_reg   <= wheel_a;
            wb_reg   <= wheel_b;
            dx_reg   <= delta_x;
            dy_reg   <= delta_y;
        end
        if (advance)
        begin
            rep_valid_reg   <= send;
            rep_buttons_reg <= send ? buttons_step : '0;
            rep_x_reg       <= send ? $signed(sum_x) : '0;
            rep_y_reg       <= send ? $signed(sum_y) : '0;
            rep_wheel_reg   <= send ? wheel_step : mfre_pkg::WHEEL_NONE;
            prof_chg_reg    <= prof_chg_step;
            cpi_code_reg    <= cpi_code_step;
            rate_chg_reg    <= rate_chg_step;
        end
    end

    assign out_valid       = out_valid_reg;
    assign report_valid    = rep_valid_reg;
    assign report_buttons  = rep_buttons_reg;
    assign report_x        = rep_x_reg;
    assign report_y        = rep_y_reg;
    assign report_wheel    = rep_wheel_reg;
    assign profile_changed = prof_chg_reg;
    assign new_profile     = profile_reg;
    assign sensor_cpi_code = cpi_code_reg;
    assign rate_changed    = rate_chg_reg;
    assign new_skip        = skip_set_reg;

endmodule

FILE: src/mfre_checker.sv
// port-level checker for the mouse frame report engine, bound to the top level
`include "mouse_frame_report_engine_macros.svh"

module mfre_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic                                   report_valid,
    input  logic [mfre_pkg::NUM_BUTTONS-1:0]       report_buttons,
    input  logic signed [mfre_pkg::MOTION_W-1:0]   report_x,
    input  logic signed [mfre_pkg::MOTION_W-1:0]   report_y,
    input  logic signed [mfre_pkg::WHEEL_W-1:0]    report_wheel,
    input  logic                                   profile_changed,
    input  logic [mfre_pkg::PROFILE_W-1:0]         new_profile,
    input  logic [mfre_pkg::CPI_CODE_W-1:0]        sensor_cpi_code
);

    // a stalled result transfer holds
    `MFRE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(report_x) && $stable(report_buttons), "stalled result changed")

    // no report means an empty report body
    `MFRE_ASSERT_NOW(a_empty_report, out_valid && !report_valid, report_buttons == '0 && report_x == '0 && report_y == '0 && report_wheel == mfre_pkg::WHEEL_NONE, "report body set without report")

    // wheel step is never minus two
    `MFRE_ASSERT_NOW(a_wheel_range, out_valid, report_wheel == mfre_pkg::WHEEL_NONE || report_wheel == mfre_pkg::WHEEL_POS || report_wheel == mfre_pkg::WHEEL_NEG, "wheel step out of range")

    // sensor code matches the profile it changed to
    `MFRE_ASSERT_NOW(a_cpi_code, out_valid && profile_changed, (new_profile == mfre_pkg::PROFILE_0 && sensor_cpi_code == mfre_pkg::CPI_CODE_P0) || (new_profile == mfre_pkg::PROFILE_1 && sensor_cpi_code == mfre_pkg::CPI_CODE_P1) || (new_profile == mfre_pkg::PROFILE_2 && sensor_cpi_code == mfre_pkg::CPI_CODE_P2), "cpi code mismatch")

    // no profile change means no sensor code
    `MFRE_ASSERT_NOW(a_cpi_idle, out_valid && !profile_changed, sensor_cpi_code == mfre_pkg::CPI_CODE_NONE, "cpi code without profile change")

endmodule

bind mouse_frame_report_engine mfre_checker u_mfre_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .report_valid    (report_valid),
    .report_buttons  (report_buttons),
    .report_x        (report_x),
    .report_y        (report_y),
    .report_wheel    (report_wheel),
    .profile_changed (profile_changed),
    .new_profile     (new_profile),
    .sensor_cpi_code (sensor_cpi_code)
);
